/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
// EVX_ASSERT is held off while rst is high; EVX_ASSERT_RST is checked at every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EVX_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EVX_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EVX_ASSERT(name, prop, msg)
`define EVX_ASSERT_RST(name, prop, msg)
`endif
`endif

/* hw/rtl/evx_pkg.sv */
`default_nettype none
package evx_pkg;

  localparam int FRACTION_BITS_DEF   = 16;
  localparam int TRIG_ITERATIONS_DEF = 16;
  localparam int LANES               = 3;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [31:0] q30_t;
  typedef logic [31:0]        phase_t;

  typedef coord_t [LANES-1:0] coord_set_t;
  typedef phase_t [LANES-1:0] phase_set_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    q30_t s;
    q30_t c;
  } trig_t;

  typedef trig_t [LANES-1:0] trig_set_t;

  // Row-major 3x3, entry (r, k) at index 3*r + k
  typedef q30_t [8:0] matrix_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t angle_x_deg;
    coord_t angle_y_deg;
    coord_t angle_z_deg;
  } in_item_t;

  typedef struct packed {
    coord_t rotated_x;
    coord_t rotated_y;
    coord_t rotated_z;
    logic   saturated_flag;
  } out_item_t;

  localparam q30_t ONE_Q30      = 32'sh4000_0000;
  localparam q30_t INV_GAIN_Q30 = 32'sh26DD_3B6A;
  localparam logic signed [63:0] HALF_Q30 = 64'sh0000_0000_2000_0000;
  localparam coord_t COORD_MAX  = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN  = 32'sh8000_0000;

  // atan(2^-i) as binary phase, one full turn = 2^32, truncated
  localparam logic [31:0] ATAN_PHASE [30] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // Clamp to [-1, 1] in Q30
  function automatic q30_t clamp_unit(input logic signed [33:0] v);
    q30_t r;
    if (v > 34'(ONE_Q30)) begin
      r = ONE_Q30;
    end else if (v < -34'(ONE_Q30)) begin
      r = -ONE_Q30;
    end else begin
      r = q30_t'(v[31:0]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/evx_stream_if.sv */
`default_nettype none
interface evx_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/evx_phase.sv */
`default_nettype none
module evx_phase #(
  parameter int FRACTION_BITS = evx_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  evx_pkg::coord_set_t angle,
  input  evx_pkg::point_t     point,
  output logic                dn_valid,
  input  logic                dn_ready,
  output evx_pkg::phase_set_t phase,
  output evx_pkg::point_t     point_delayed
);
  import evx_pkg::*;

  localparam int     SHIFT      = 32 - FRACTION_BITS;
  localparam longint FULL       = longint'(360) << FRACTION_BITS;
  // smallest multiple of a full turn that lifts any 32-bit angle to >= 0
  localparam longint OFFSET     = ((longint'(1) << 31) + FULL - 1) / FULL * FULL;
  localparam int     DIVISOR    = 360;
  localparam int     ROUND_BIAS = 180;
  localparam int     LAST       = 5;

  // floor(u / 360) as (u * RECIP_360) >> 34, exact for u below 2^25
  localparam logic [25:0] RECIP_360       = 26'd47721859;
  localparam int          RECIP_360_SHIFT = 34;
  // floor(w / 45) as (w * RECIP_45) >> 36, exact for w below 2^30
  localparam logic [30:0] RECIP_45        = 31'd1527099484;
  localparam int          RECIP_45_SHIFT  = 36;
  // 2^32 = 360 * TURN_DIV_360 + 256
  localparam logic [31:0] TURN_DIV_360    = 32'd11930464;

  typedef struct packed {
    logic [24:0] u;
    logic [16:0] qu;
    logic [8:0]  ru;
    logic [31:0] frac_hi;
    logic [29:0] w;
    logic [24:0] q2;
    logic [31:0] ph;
  } lane_t;
  typedef lane_t [LANES-1:0] lane_set_t;

  lane_set_t    st_q [LAST+1];
  lane_set_t    st_next [LAST+1];
  point_t       point_q [LAST+1];
  logic [LAST:0] vld;
  logic [LAST:0] rdy;

  // Bias the angle by whole turns; split whole degrees from the fraction
  function automatic lane_t load_lane(input coord_t a);
    logic [33:0] biased;
    lane_t l;
    biased    = 34'(a) + 34'(OFFSET);
    l         = '0;
    l.u       = 25'(biased >> FRACTION_BITS);
    l.frac_hi = 32'(biased[FRACTION_BITS-1:0]) << SHIFT;
    return l;
  endfunction

  function automatic lane_t div_coarse(input lane_t s);
    logic [50:0] p;
    lane_t l;
    l    = s;
    p    = 51'(s.u) * 51'(RECIP_360);
    l.qu = 17'(p >> RECIP_360_SHIFT);
    return l;
  endfunction

  // Whole degrees modulo one turn
  function automatic lane_t div_fix(input lane_t s);
    lane_t l;
    l    = s;
    l.ru = 9'(s.u - 25'(s.qu) * 25'(DIVISOR));
    return l;
  endfunction

  // Leftover of ru * 2^32 over 360 is ru * 256; divide by 8 here, by 45 next
  function automatic lane_t fine_load(input lane_t s);
    logic [32:0] v;
    lane_t l;
    l   = s;
    v   = {16'd0, s.ru, 8'd0} + 33'(s.frac_hi) + 33'(ROUND_BIAS);
    l.w = v[32:3];
    return l;
  endfunction

  function automatic lane_t fine_div(input lane_t s);
    logic [60:0] p;
    lane_t l;
    l    = s;
    p    = 61'(s.w) * 61'(RECIP_45);
    l.q2 = 25'(p >> RECIP_45_SHIFT);
    return l;
  endfunction

  function automatic lane_t combine(input lane_t s);
    lane_t l;
    l    = s;
    l.ph = 32'(s.ru) * TURN_DIV_360 + 32'(s.q2);
    return l;
  endfunction

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      st_next[0][l] = load_lane(angle[l]);
      st_next[1][l] = div_coarse(st_q[0][l]);
      st_next[2][l] = div_fix(st_q[1][l]);
      st_next[3][l] = fine_load(st_q[2][l]);
      st_next[4][l] = fine_div(st_q[3][l]);
      st_next[5][l] = combine(st_q[4][l]);
    end
  end

  // A stage takes new data when empty or when its successor moves
  always_comb begin
    rdy[LAST] = !vld[LAST] || dn_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= up_valid;
      for (int k = 1; k <= LAST; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st_q[0]    <= st_next[0];
      point_q[0] <= point;
    end
    for (int k = 1; k <= LAST; k++) begin
      if (rdy[k]) begin
        st_q[k]    <= st_next[k];
        point_q[k] <= point_q[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      phase[l] = st_q[LAST][l].ph;
    end
  end

  assign up_ready      = rdy[0];
  assign dn_valid      = vld[LAST];
  assign point_delayed = point_q[LAST];

endmodule
`default_nettype wire

/* hw/rtl/evx_cordic.sv */
`default_nettype none
module evx_cordic #(
  parameter int TRIG_ITERATIONS = evx_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  evx_pkg::phase_set_t phase,
  input  evx_pkg::point_t     point,
  output logic                dn_valid,
  input  logic                dn_ready,
  output evx_pkg::trig_set_t  trig,
  output evx_pkg::point_t     point_delayed
);
  import evx_pkg::*;

  localparam int ITER_GROUP = 2;
  localparam int NIT        = (TRIG_ITERATIONS + ITER_GROUP - 1) / ITER_GROUP;
  localparam int LAST       = NIT + 1;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  typedef struct packed {
    quad_t              quad;
    q30_t               x;
    q30_t               y;
    logic signed [31:0] z;
  } cst_t;
  typedef cst_t [LANES-1:0] cst_set_t;

  cst_set_t  cst_q [NIT+1];
  cst_set_t  cst_entry;
  cst_set_t  cst_next [1:NIT];
  trig_set_t trig_q;
  trig_set_t trig_next;
  point_t    point_q [LAST+1];
  logic [LAST:0] vld;
  logic [LAST:0] rdy;

  // Split off the quadrant; the residual lies within an eighth of a turn
  function automatic cst_t prep(input phase_t ph);
    logic [31:0] biased;
    cst_t c;
    biased = ph + 32'h2000_0000;
    c.quad = quad_t'(biased[31:30]);
    c.z    = ph - {biased[31:30], 30'd0};
    c.x    = INV_GAIN_Q30;
    c.y    = '0;
    return c;
  endfunction

  function automatic cst_t rotate(input cst_t s, input int first);
    cst_t c;
    q30_t xs;
    q30_t ys;
    int   i;
    c = s;
    for (int j = 0; j < ITER_GROUP; j++) begin
      i = first + j;
      if (i < TRIG_ITERATIONS) begin
        xs = c.x >>> i;
        ys = c.y >>> i;
        if (!c.z[31]) begin
          c.x = c.x - ys;
          c.y = c.y + xs;
          c.z = c.z - $signed(ATAN_PHASE[i[4:0]]);
        end else begin
          c.x = c.x + ys;
          c.y = c.y - xs;
          c.z = c.z + $signed(ATAN_PHASE[i[4:0]]);
        end
      end
    end
    return c;
  endfunction

  // Fold the quadrant back in, then clamp to unit range
  function automatic trig_t unfold(input cst_t c);
    logic signed [33:0] s;
    logic signed [33:0] k;
    trig_t t;
    case (c.quad)
      QUAD_0: begin
        k = 34'(c.x);
        s = 34'(c.y);
      end
      QUAD_90: begin
        k = -34'(c.y);
        s = 34'(c.x);
      end
      QUAD_180: begin
        k = -34'(c.x);
        s = -34'(c.y);
      end
      default: begin
        k = 34'(c.y);
        s = -34'(c.x);
      end
    endcase
    t.s = clamp_unit(s);
    t.c = clamp_unit(k);
    return t;
  endfunction

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cst_entry[l] = prep(phase[l]);
      trig_next[l] = unfold(cst_q[NIT][l]);
    end
    for (int k = 1; k <= NIT; k++) begin
      for (int l = 0; l < LANES; l++) begin
        cst_next[k][l] = rotate(cst_q[k-1][l], (k - 1) * ITER_GROUP);
      end
    end
  end

  always_comb begin
    rdy[LAST] = !vld[LAST] || dn_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= up_valid;
      for (int k = 1; k <= LAST; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      cst_q[0]   <= cst_entry;
      point_q[0] <= point;
    end
    for (int k = 1; k <= NIT; k++) begin
      if (rdy[k]) cst_q[k] <= cst_next[k];
    end
    if (rdy[LAST]) trig_q <= trig_next;
    for (int k = 1; k <= LAST; k++) begin
      if (rdy[k]) point_q[k] <= point_q[k-1];
    end
  end

  assign up_ready      = rdy[0];
  assign dn_valid      = vld[LAST];
  assign trig          = trig_q;
  assign point_delayed = point_q[LAST];

endmodule
`default_nettype wire

/* hw/rtl/evx_matrix.sv */
`default_nettype none
module evx_matrix (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  evx_pkg::trig_set_t trig,
  input  evx_pkg::point_t    point,
  output logic               dn_valid,
  input  logic               dn_ready,
  output evx_pkg::matrix_t   matrix,
  output evx_pkg::point_t    point_delayed
);
  import evx_pkg::*;

  localparam int NST = 4;

  typedef logic signed [63:0] wide_t;

  typedef struct packed {
    wide_t sxsy, cxsy, cycz, cysz, cxsz, cxcz, sxcy, sxsz, sxcz, cxcy;
    q30_t  sy, sz, cz;
  } raw1_t;

  typedef struct packed {
    q30_t sxsy, cxsy, cycz, cysz, cxsz, cxcz, sxcy, sxsz, sxcz, cxcy;
    q30_t sy, sz, cz;
  } rnd1_t;

  typedef struct packed {
    wide_t sxsy_cz, sxsy_sz, cxsy_cz, cxsy_sz;
    q30_t  cycz, cysz, cxsz, cxcz, sxcy, sxsz, sxcz, cxcy, sy;
  } raw2_t;

  raw1_t   st0, st0_next;
  rnd1_t   st1, st1_next;
  raw2_t   st2, st2_next;
  matrix_t st3, st3_next;
  point_t  point_q [NST];
  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;

  function automatic q30_t rnd_q30(input wide_t p);
    wide_t t;
    t = (p + HALF_Q30) >>> 30;
    return q30_t'(t[31:0]);
  endfunction

  function automatic wide_t mul(input q30_t a, input q30_t b);
    return 64'(a) * 64'(b);
  endfunction

  // First products of the sines and cosines
  always_comb begin
    st0_next.sxsy = mul(trig[0].s, trig[1].s);
    st0_next.cxsy = mul(trig[0].c, trig[1].s);
    st0_next.cycz = mul(trig[1].c, trig[2].c);
    st0_next.cysz = mul(trig[1].c, trig[2].s);
    st0_next.cxsz = mul(trig[0].c, trig[2].s);
    st0_next.cxcz = mul(trig[0].c, trig[2].c);
    st0_next.sxcy = mul(trig[0].s, trig[1].c);
    st0_next.sxsz = mul(trig[0].s, trig[2].s);
    st0_next.sxcz = mul(trig[0].s, trig[2].c);
    st0_next.cxcy = mul(trig[0].c, trig[1].c);
    st0_next.sy   = trig[1].s;
    st0_next.sz   = trig[2].s;
    st0_next.cz   = trig[2].c;
  end

  always_comb begin
    st1_next.sxsy = rnd_q30(st0.sxsy);
    st1_next.cxsy = rnd_q30(st0.cxsy);
    st1_next.cycz = rnd_q30(st0.cycz);
    st1_next.cysz = rnd_q30(st0.cysz);
    st1_next.cxsz = rnd_q30(st0.cxsz);
    st1_next.cxcz = rnd_q30(st0.cxcz);
    st1_next.sxcy = rnd_q30(st0.sxcy);
    st1_next.sxsz = rnd_q30(st0.sxsz);
    st1_next.sxcz = rnd_q30(st0.sxcz);
    st1_next.cxcy = rnd_q30(st0.cxcy);
    st1_next.sy   = st0.sy;
    st1_next.sz   = st0.sz;
    st1_next.cz   = st0.cz;
  end

  // Triple products, left to right
  always_comb begin
    st2_next.sxsy_cz = mul(st1.sxsy, st1.cz);
    st2_next.sxsy_sz = mul(st1.sxsy, st1.sz);
    st2_next.cxsy_cz = mul(st1.cxsy, st1.cz);
    st2_next.cxsy_sz = mul(st1.cxsy, st1.sz);
    st2_next.cycz    = st1.cycz;
    st2_next.cysz    = st1.cysz;
    st2_next.cxsz    = st1.cxsz;
    st2_next.cxcz    = st1.cxcz;
    st2_next.sxcy    = st1.sxcy;
    st2_next.sxsz    = st1.sxsz;
    st2_next.sxcz    = st1.sxcz;
    st2_next.cxcy    = st1.cxcy;
    st2_next.sy      = st1.sy;
  end

  always_comb begin
    st3_next[0] = clamp_unit(34'(st2.cycz));
    st3_next[1] = clamp_unit(-34'(st2.cysz));
    st3_next[2] = clamp_unit(34'(st2.sy));
    st3_next[3] = clamp_unit(34'(st2.cxsz) + 34'(rnd_q30(st2.sxsy_cz)));
    st3_next[4] = clamp_unit(34'(st2.cxcz) - 34'(rnd_q30(st2.sxsy_sz)));
    st3_next[5] = clamp_unit(-34'(st2.sxcy));
    st3_next[6] = clamp_unit(34'(st2.sxsz) - 34'(rnd_q30(st2.cxsy_cz)));
    st3_next[7] = clamp_unit(34'(st2.sxcz) + 34'(rnd_q30(st2.cxsy_sz)));
    st3_next[8] = clamp_unit(34'(st2.cxcy));
  end

  always_comb begin
    rdy[NST-1] = !vld[NST-1] || dn_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= up_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st0        <= st0_next;
      point_q[0] <= point;
    end
    if (rdy[1]) st1 <= st1_next;
    if (rdy[2]) st2 <= st2_next;
    if (rdy[3]) st3 <= st3_next;
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) point_q[k] <= point_q[k-1];
    end
  end

  assign up_ready      = rdy[0];
  assign dn_valid      = vld[NST-1];
  assign matrix        = st3;
  assign point_delayed = point_q[NST-1];

endmodule
`default_nettype wire

/* hw/rtl/evx_apply.sv */
`default_nettype none
module evx_apply (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  evx_pkg::matrix_t    matrix,
  input  evx_pkg::point_t     point,
  output logic                dn_valid,
  input  logic                dn_ready,
  output evx_pkg::out_item_t  result
);
  import evx_pkg::*;

  localparam int NST = 3;

  typedef logic signed [63:0] wide_t;
  typedef wide_t [8:0] prod_set_t;
  typedef wide_t [2:0] sum_set_t;

  prod_set_t prod_q, prod_next;
  sum_set_t  sum_q, sum_next;
  out_item_t res_q, res_next;
  coord_t    coord [3];
  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;

  assign coord[0] = point.x;
  assign coord[1] = point.y;
  assign coord[2] = point.z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_next[3*r+k] = 64'(matrix[3*r+k]) * 64'(coord[k]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_next[r] = prod_q[3*r] + prod_q[3*r+1] + prod_q[3*r+2] + HALF_Q30;
    end
  end

  // Shift down to the coordinate scale and clamp to 32 bits
  always_comb begin
    wide_t  v;
    coord_t c [3];
    logic   sat;
    sat = 1'b0;
    for (int r = 0; r < 3; r++) begin
      v = sum_q[r] >>> 30;
      if (v > 64'(COORD_MAX)) begin
        c[r] = COORD_MAX;
        sat  = 1'b1;
      end else if (v < 64'(COORD_MIN)) begin
        c[r] = COORD_MIN;
        sat  = 1'b1;
      end else begin
        c[r] = coord_t'(v[31:0]);
      end
    end
    res_next.rotated_x      = c[0];
    res_next.rotated_y      = c[1];
    res_next.rotated_z      = c[2];
    res_next.saturated_flag = sat;
  end

  always_comb begin
    rdy[NST-1] = !vld[NST-1] || dn_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= up_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) prod_q <= prod_next;
    if (rdy[1]) sum_q  <= sum_next;
    if (rdy[2]) res_q  <= res_next;
  end

  assign up_ready = rdy[0];
  assign dn_valid = vld[NST-1];
  assign result   = res_q;

endmodule
`default_nettype wire

/* hw/rtl/euler_xyz_vector_rotate_top.sv */
// Channel   Dir  Payload                                          Handshake
// points    in   point_x/y/z, angle_x/y/z_deg (signed Q15.16)     valid/ready
// results   out  rotated_x/y/z (signed Q15.16), saturated_flag    valid/ready
//
// One transfer in and one out per cycle, sustained while results.ready stays
// high. At the defaults the CORDIC (two iterations a stage) has the most stages,
// and the reduction to a binary phase takes six stages, with reciprocal
// multiplies by 1/360 and by 1/45 (after a divide by 8).
// Reset clears only the stage valid bits. Every stage holds while its
// successor is full and stalled, so a stall back-pressures only as far as
// the first empty stage; bubbles are squeezed out.
`default_nettype none
`include "assert_macros.svh"
module euler_xyz_vector_rotate_top #(
  parameter int FRACTION_BITS   = evx_pkg::FRACTION_BITS_DEF,
  parameter int TRIG_ITERATIONS = evx_pkg::TRIG_ITERATIONS_DEF
) (
  input logic          clk,
  input logic          rst,
  evx_stream_if.sink   points,
  evx_stream_if.source results
);
  import evx_pkg::*;

  coord_set_t angle;
  point_t     point;

  // degrees to binary phase
  logic       ph_valid, ph_ready;
  phase_set_t ph_phase;
  point_t     ph_point;

  // sine and cosine
  logic       tr_valid, tr_ready;
  trig_set_t  tr_trig;
  point_t     tr_point;

  // rotation matrix
  logic       mx_valid, mx_ready;
  matrix_t    mx_matrix;
  point_t     mx_point;

  out_item_t  result;
  logic       at_rail;

  assign angle[0] = points.data.angle_x_deg;
  assign angle[1] = points.data.angle_y_deg;
  assign angle[2] = points.data.angle_z_deg;
  assign point.x  = points.data.point_x;
  assign point.y  = points.data.point_y;
  assign point.z  = points.data.point_z;

  // Reduce each angle by whole turns and scale to a 32-bit phase
  evx_phase #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_phase (
    .clk           (clk),
    .rst           (rst),
    .up_valid      (points.valid),
    .up_ready      (points.ready),
    .angle         (angle),
    .point         (point),
    .dn_valid      (ph_valid),
    .dn_ready      (ph_ready),
    .phase         (ph_phase),
    .point_delayed (ph_point)
  );

  // Three CORDIC lanes, one per axis
  evx_cordic #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_cordic (
    .clk           (clk),
    .rst           (rst),
    .up_valid      (ph_valid),
    .up_ready      (ph_ready),
    .phase         (ph_phase),
    .point         (ph_point),
    .dn_valid      (tr_valid),
    .dn_ready      (tr_ready),
    .trig          (tr_trig),
    .point_delayed (tr_point)
  );

  // Build Rx*Ry*Rz in Q30
  evx_matrix u_matrix (
    .clk           (clk),
    .rst           (rst),
    .up_valid      (tr_valid),
    .up_ready      (tr_ready),
    .trig          (tr_trig),
    .point         (tr_point),
    .dn_valid      (mx_valid),
    .dn_ready      (mx_ready),
    .matrix        (mx_matrix),
    .point_delayed (mx_point)
  );

  // Multiply the point through, round and saturate; last stage is the output register
  evx_apply u_apply (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mx_valid),
    .up_ready (mx_ready),
    .matrix   (mx_matrix),
    .point    (mx_point),
    .dn_valid (results.valid),
    .dn_ready (results.ready),
    .result   (result)
  );

  assign results.data = result;

  assign at_rail = results.data.rotated_x == COORD_MAX ||
                   results.data.rotated_x == COORD_MIN ||
                   results.data.rotated_y == COORD_MAX ||
                   results.data.rotated_y == COORD_MIN ||
                   results.data.rotated_z == COORD_MAX ||
                   results.data.rotated_z == COORD_MIN;

  // A raised flag means at least one component sits at a rail
  `EVX_ASSERT(a_sat_at_rail, results.valid && results.data.saturated_flag |-> at_rail, "saturated_flag set with no clamped component")
  // Nothing leaves straight after reset
  `EVX_ASSERT_RST(a_empty_after_reset, rst |=> !results.valid, "result valid right after reset")
  // A ready sink lets every stage move, so the source side must be ready too
  `EVX_ASSERT(a_ready_chain, results.ready |-> points.ready, "input stalled while output is drained")

endmodule
`default_nettype wire
